@@ rtl/slfc_pkg.sv @@
// ----------------------------------------------------------------------------
// slfc_pkg
// Shared types and fixed constants of the stereo long FIR convolver:
// sample and tap formats, memory banking, scaling constants and the
// controller-to-datapath command and status structs.
// ----------------------------------------------------------------------------
package slfc_pkg;

    // Sample history: 4096 samples split over four banks
    localparam int HIST_DEPTH  = 4096;
    localparam int HIST_AW     = 12;
    localparam int LANES       = 4;
    localparam int LANE_W      = 2;
    localparam int HBANK_DEPTH = HIST_DEPTH / LANES;
    localparam int HBANK_AW    = HIST_AW - LANE_W;
    localparam int CHANNELS    = 2;

    // Data formats
    localparam int SAMPLE_W   = 32;
    localparam int COEF_W     = 24;
    localparam int IDX_W      = 12;
    localparam int PEAK_W     = 31;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int QUAD_W     = PROD_W + 2;
    localparam int ACC_W      = PROD_W + HIST_AW;
    localparam int FRAC_SHIFT = 23;
    localparam int Q_W        = ACC_W - FRAC_SHIFT;

    // Output scaling: gain 64042 / 2^16, about -0.2 dB
    localparam int GAIN_W     = 16;
    localparam int SCALED_W   = SAMPLE_W + GAIN_W;
    localparam logic [GAIN_W-1:0]          GAIN_Q16 = 16'd64042;
    localparam logic signed [SAMPLE_W-1:0] CLAMP_HI = 32'sh7FFF_FE00;
    localparam logic signed [SAMPLE_W-1:0] CLAMP_LO = 32'sh8000_0000;
    localparam logic [SAMPLE_W-1:0]        OUT_MASK = 32'hFFFF_FFFC;

    // Length of the drain state that lets the last tap group reach the accumulator
    localparam int DRAIN_CYCLES = 4;

    // Request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_MAC,
        ST_DRAIN,
        ST_CLAMP,
        ST_SCALE,
        ST_ROUND,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                clear_wr;
        logic                accept;
        logic                coef_wr;
        logic                hist_wr;
        logic                mac_issue;
        logic                clamp;
        logic                scale;
        logic                round;
        logic                emit;
        logic [HBANK_AW-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic is_coef;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/slfc_ram.sv @@
// ----------------------------------------------------------------------------
// slfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/slfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// slfc_ctrl
// Sequencer of the convolver: clearing pass after reset, request dispatch,
// tap walk, pipeline drain, output scaling steps and result hand-off.
// ----------------------------------------------------------------------------
module slfc_ctrl #(
    parameter int TAPS = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  slfc_pkg::t_sts i_sts,
    output slfc_pkg::t_cmd o_cmd
);

    import slfc_pkg::*;

    localparam int TAP_LIM   = (TAPS < HIST_DEPTH) ? TAPS : HIST_DEPTH;
    localparam int TAP_DEPTH = (TAP_LIM + LANES - 1) / LANES;
    localparam logic [HBANK_AW-1:0] LAST_GROUP = HBANK_AW'(TAP_DEPTH - 1);
    localparam logic [HBANK_AW-1:0] LAST_CLEAR = HBANK_AW'(HBANK_DEPTH - 1);
    localparam logic [HBANK_AW-1:0] LAST_DRAIN = HBANK_AW'(DRAIN_CYCLES - 1);

    t_state              r_state, n_state;
    logic [HBANK_AW-1:0] r_count, n_count;

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            ST_CLEAR: begin
                n_count = r_count + 1'b1;
                if (r_count == LAST_CLEAR) begin
                    n_state = ST_IDLE;
                    n_count = '0;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_count = '0;
                n_state = i_sts.is_coef ? ST_IDLE : ST_MAC;
            end
            ST_MAC: begin
                n_count = r_count + 1'b1;
                if (r_count == LAST_GROUP) begin
                    n_state = ST_DRAIN;
                    n_count = '0;
                end
            end
            ST_DRAIN: begin
                n_count = r_count + 1'b1;
                if (r_count == LAST_DRAIN) begin
                    n_state = ST_CLAMP;
                    n_count = '0;
                end
            end
            ST_CLAMP: n_state = ST_SCALE;
            ST_SCALE: n_state = ST_ROUND;
            ST_ROUND: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_count = '0;
            end
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd       = '0;
        o_cmd.count = r_count;
        case (r_state)
            ST_CLEAR:    o_cmd.clear_wr  = 1'b1;
            ST_IDLE:     o_cmd.accept    = i_in_valid;
            ST_DISPATCH: begin
                o_cmd.coef_wr = i_sts.is_coef;
                o_cmd.hist_wr = !i_sts.is_coef;
            end
            ST_MAC:      o_cmd.mac_issue = 1'b1;
            ST_CLAMP:    o_cmd.clamp     = 1'b1;
            ST_SCALE:    o_cmd.scale     = 1'b1;
            ST_ROUND:    o_cmd.round     = 1'b1;
            ST_EMIT:     o_cmd.emit      = i_sts.out_free;
            default:     o_cmd.count     = r_count;
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

`ifndef SYNTHESIS
    a_group_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MAC |-> r_count <= LAST_GROUP)
        else $error("tap walk ran past the last tap group");

    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("result loaded over a result still waiting");

    a_frame_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DISPATCH && !i_sts.is_coef |=> r_state == ST_MAC && r_count == '0)
        else $error("sample frame did not start the tap walk at group zero");
`endif

endmodule

@@ rtl/slfc_datapath.sv @@
// ----------------------------------------------------------------------------
// slfc_datapath
// Banked sample history and tap stores, four multiply lanes per output
// channel with an adder tree and accumulator, clamp and gain stages,
// peak trackers and the result register.
// ----------------------------------------------------------------------------
module slfc_datapath #(
    parameter int TAPS = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  slfc_pkg::t_cmd           i_cmd,
    output slfc_pkg::t_sts           o_sts,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_wdata,
    input  logic                     i_req_type,
    input  logic [31:0]              i_sample_left,
    input  logic [31:0]              i_sample_right,
    input  logic                     i_coef_channel,
    input  logic [11:0]              i_coef_index,
    input  logic [23:0]              i_coef_value,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [31:0]              o_out_left,
    output logic [31:0]              o_out_right,
    output logic [30:0]              o_in_peak_left,
    output logic [30:0]              o_in_peak_right,
    output logic [30:0]              o_out_peak_left,
    output logic [30:0]              o_out_peak_right
);

    import slfc_pkg::*;

    localparam int TAP_LIM   = (TAPS < HIST_DEPTH) ? TAPS : HIST_DEPTH;
    localparam int TAP_DEPTH = (TAP_LIM + LANES - 1) / LANES;
    localparam int TAW       = $clog2(TAP_DEPTH);

    function automatic logic [PEAK_W-1:0] abs_sat(input logic [SAMPLE_W-1:0] x);
        logic [SAMPLE_W-1:0] neg;
        neg = ~x + 1'b1;
        if (x == CLAMP_LO) begin
            abs_sat = '1;
        end else if (x[SAMPLE_W-1]) begin
            abs_sat = neg[PEAK_W-1:0];
        end else begin
            abs_sat = x[PEAK_W-1:0];
        end
    endfunction

    // Configuration and request latch
    logic                r_input_select;
    logic                r_req_type;
    logic [SAMPLE_W-1:0] r_sample_left;
    logic [SAMPLE_W-1:0] r_sample_right;
    logic                r_coef_channel;
    logic [IDX_W-1:0]    r_coef_index;
    logic [COEF_W-1:0]   r_coef_value;
    logic [HIST_AW-1:0]  r_ptr;

    // Memories
    logic [HBANK_AW-1:0] h_raddr [LANES];
    logic [SAMPLE_W-1:0] h_rdata [LANES];
    logic                h_we    [LANES];
    logic [HBANK_AW-1:0] h_waddr;
    logic [SAMPLE_W-1:0] h_wdata;
    logic [SAMPLE_W-1:0] hist_sample;
    logic [HIST_AW-1:0]  group_base;
    logic [SAMPLE_W-1:0] h_lane  [LANES];
    logic [COEF_W-1:0]   t_rdata [CHANNELS][LANES];
    logic [TAW-1:0]      t_waddr;
    logic [TAW-1:0]      t_raddr;
    logic [COEF_W-1:0]   t_wdata;
    logic                coef_ok;
    logic                tap_clear;

    // Multiply-accumulate pipeline
    logic                       r_rd_v, r_prod_v, r_pair_v, r_quad_v;
    logic signed [PROD_W-1:0]   r_prod [CHANNELS][LANES];
    logic signed [PAIR_W-1:0]   r_pair [CHANNELS][2];
    logic signed [QUAD_W-1:0]   r_quad [CHANNELS];
    logic signed [ACC_W-1:0]    r_acc  [CHANNELS];

    // Output scaling
    logic signed [Q_W-1:0]  q      [CHANNELS];
    logic [SAMPLE_W-1:0]    q_sat  [CHANNELS];
    logic [SAMPLE_W-1:0]    r_qmag [CHANNELS];
    logic                   r_qneg [CHANNELS];
    logic [SCALED_W-1:0]    r_scaled [CHANNELS];
    logic [SAMPLE_W-1:0]    s_mag  [CHANNELS];
    logic [SAMPLE_W-1:0]    s_val  [CHANNELS];
    logic [SAMPLE_W-1:0]    r_y    [CHANNELS];
    logic [SAMPLE_W-1:0]    y_neg  [CHANNELS];
    logic [PEAK_W-1:0]      y_abs  [CHANNELS];
    logic [PEAK_W-1:0]      n_out_peak [CHANNELS];

    // Peaks and result register
    logic [PEAK_W-1:0]   r_in_peak  [CHANNELS];
    logic [PEAK_W-1:0]   r_out_peak [CHANNELS];
    logic [PEAK_W-1:0]   in_abs     [CHANNELS];
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_left, r_out_right;
    logic [PEAK_W-1:0]   r_o_in_peak_left, r_o_in_peak_right;
    logic [PEAK_W-1:0]   r_o_out_peak_left, r_o_out_peak_right;

    // Hold the filter input select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_select <= 1'b0;
        end else if (i_cfg_we) begin
            r_input_select <= i_cfg_wdata;
        end
    end

    // Capture the request on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type     <= i_req_type;
            r_sample_left  <= i_sample_left;
            r_sample_right <= i_sample_right;
            r_coef_channel <= i_coef_channel;
            r_coef_index   <= i_coef_index;
            r_coef_value   <= i_coef_value;
        end
    end

    assign o_sts.is_coef  = (r_req_type == REQ_COEF);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // History banks: write at the pointer, read four consecutive samples
    assign hist_sample = r_input_select ? r_sample_right : r_sample_left;
    assign group_base  = r_ptr - {i_cmd.count, {LANE_W{1'b0}}};
    assign h_waddr     = i_cmd.clear_wr ? i_cmd.count : r_ptr[HIST_AW-1:LANE_W];
    assign h_wdata     = i_cmd.clear_wr ? '0 : hist_sample;

    for (genvar b = 0; b < LANES; b++) begin : g_hist
        logic [LANE_W-1:0]  lane;
        logic [HIST_AW-1:0] addr;

        assign lane       = r_ptr[LANE_W-1:0] - LANE_W'(b);
        assign addr       = group_base - HIST_AW'(lane);
        assign h_raddr[b] = addr[HIST_AW-1:LANE_W];
        assign h_we[b]    = i_cmd.clear_wr ||
                            (i_cmd.hist_wr && r_ptr[LANE_W-1:0] == LANE_W'(b));

        slfc_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (HBANK_DEPTH)
        ) u_hist_ram (
            .i_clk   (i_clk),
            .i_we    (h_we[b]),
            .i_waddr (h_waddr),
            .i_wdata (h_wdata),
            .i_raddr (h_raddr[b]),
            .o_rdata (h_rdata[b])
        );
    end

    // Rotate bank outputs into lane order
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            h_lane[l] = h_rdata[LANE_W'(r_ptr[LANE_W-1:0] - LANE_W'(l))];
        end
    end

    // Tap banks: tap k sits in lane k mod 4 at row k / 4
    assign coef_ok   = {1'b0, r_coef_index} < (IDX_W + 1)'(TAP_LIM);
    assign tap_clear = i_cmd.clear_wr && ({1'b0, i_cmd.count} < (HBANK_AW + 1)'(TAP_DEPTH));
    assign t_waddr   = i_cmd.clear_wr ? i_cmd.count[TAW-1:0]
                                      : r_coef_index[TAW+LANE_W-1:LANE_W];
    assign t_wdata   = i_cmd.clear_wr ? '0 : r_coef_value;
    assign t_raddr   = i_cmd.count[TAW-1:0];

    for (genvar c = 0; c < CHANNELS; c++) begin : g_tap_ch
        for (genvar l = 0; l < LANES; l++) begin : g_tap_lane
            logic we;

            assign we = tap_clear ||
                        (i_cmd.coef_wr && coef_ok && r_coef_channel == 1'(c) &&
                         r_coef_index[LANE_W-1:0] == LANE_W'(l));

            slfc_ram #(
                .WIDTH (COEF_W),
                .DEPTH (TAP_DEPTH)
            ) u_tap_ram (
                .i_clk   (i_clk),
                .i_we    (we),
                .i_waddr (t_waddr),
                .i_wdata (t_wdata),
                .i_raddr (t_raddr),
                .o_rdata (t_rdata[c][l])
            );
        end
    end

    // Track valid data through the multiply-add pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
            r_pair_v <= 1'b0;
            r_quad_v <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.mac_issue;
            r_prod_v <= r_rd_v;
            r_pair_v <= r_prod_v;
            r_quad_v <= r_pair_v;
        end
    end

    // Multiply, add pairs, add quads, accumulate
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CHANNELS; c++) begin
            for (int l = 0; l < LANES; l++) begin
                r_prod[c][l] <= $signed(t_rdata[c][l]) * $signed(h_lane[l]);
            end
            r_pair[c][0] <= PAIR_W'(r_prod[c][0]) + PAIR_W'(r_prod[c][1]);
            r_pair[c][1] <= PAIR_W'(r_prod[c][2]) + PAIR_W'(r_prod[c][3]);
            r_quad[c]    <= QUAD_W'(r_pair[c][0]) + QUAD_W'(r_pair[c][1]);
            if (i_cmd.hist_wr) begin
                r_acc[c] <= '0;
            end else if (r_quad_v) begin
                r_acc[c] <= r_acc[c] + ACC_W'(r_quad[c]);
            end
        end
    end

    // Drop fraction bits and clamp to the output range
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            q[c] = $signed(r_acc[c][ACC_W-1:FRAC_SHIFT]);
            if (q[c] > Q_W'(CLAMP_HI)) begin
                q_sat[c] = CLAMP_HI;
            end else if (q[c] < Q_W'(CLAMP_LO)) begin
                q_sat[c] = CLAMP_LO;
            end else begin
                q_sat[c] = q[c][SAMPLE_W-1:0];
            end
        end
    end

    // Scale the magnitude, restore the sign, clear the two low bits
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            s_mag[c] = r_scaled[c][SCALED_W-1:GAIN_W];
            s_val[c] = r_qneg[c] ? (~s_mag[c] + 1'b1) : s_mag[c];
            y_neg[c] = ~r_y[c] + 1'b1;
            y_abs[c] = r_y[c][SAMPLE_W-1] ? y_neg[c][PEAK_W-1:0] : r_y[c][PEAK_W-1:0];
            n_out_peak[c] = (y_abs[c] > r_out_peak[c]) ? y_abs[c] : r_out_peak[c];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (i_cmd.clamp) begin
                r_qneg[c] <= q_sat[c][SAMPLE_W-1];
                r_qmag[c] <= q_sat[c][SAMPLE_W-1] ? (~q_sat[c] + 1'b1) : q_sat[c];
            end
            if (i_cmd.scale) begin
                r_scaled[c] <= r_qmag[c] * GAIN_Q16;
            end
            if (i_cmd.round) begin
                r_y[c] <= s_val[c] & OUT_MASK;
            end
        end
    end

    // Input peaks, output peaks and history pointer
    assign in_abs[0] = abs_sat(r_sample_left);
    assign in_abs[1] = abs_sat(r_sample_right);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_in_peak[c]  <= '0;
                r_out_peak[c] <= '0;
            end
        end else begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (i_cmd.hist_wr && in_abs[c] > r_in_peak[c]) begin
                    r_in_peak[c] <= in_abs[c];
                end
                if (i_cmd.emit) begin
                    r_out_peak[c] <= n_out_peak[c];
                end
            end
            if (i_cmd.emit) begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
    end

    // Result register: load on emit, release on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_left         <= r_y[0];
            r_out_right        <= r_y[1];
            r_o_in_peak_left   <= r_in_peak[0];
            r_o_in_peak_right  <= r_in_peak[1];
            r_o_out_peak_left  <= n_out_peak[0];
            r_o_out_peak_right <= n_out_peak[1];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_left       = r_out_left;
    assign o_out_right      = r_out_right;
    assign o_in_peak_left   = r_o_in_peak_left;
    assign o_in_peak_right  = r_o_in_peak_right;
    assign o_out_peak_left  = r_o_out_peak_left;
    assign o_out_peak_right = r_o_out_peak_right;

`ifndef SYNTHESIS
    a_low_bits_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_left[1:0] == 2'b00 && r_out_right[1:0] == 2'b00)
        else $error("result carries nonzero low bits");
`endif

endmodule

@@ rtl/stereo_long_fir_convolver.sv @@
// ----------------------------------------------------------------------------
// stereo_long_fir_convolver
// A sample frame is accepted only in the idle state, so the next frame waits
// until the current one is through: the tap walk reads four history banks and
// four tap banks per channel each cycle and feeds four multipliers per
// output channel, followed by an adder drain and the clamp, scale and round
// steps; the result is then emitted once the output register is free. A
// coefficient write passes through dispatch back to idle and produces no
// result. After reset a clearing pass zeroes the history and tap memories;
// no request is accepted during it, while input_select writes are taken at
// any time. The result sits in an output register, so the next request is
// accepted while a result still waits for its transfer.
// ----------------------------------------------------------------------------
module stereo_long_fir_convolver #(
    parameter int TAPS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_sample_left,
    input  logic [31:0] i_sample_right,
    input  logic        i_coef_channel,
    input  logic [11:0] i_coef_index,
    input  logic [23:0] i_coef_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_left,
    output logic [31:0] o_out_right,
    output logic [30:0] o_in_peak_left,
    output logic [30:0] o_in_peak_right,
    output logic [30:0] o_out_peak_left,
    output logic [30:0] o_out_peak_right
);

    import slfc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    slfc_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Memories, arithmetic and result register
    slfc_datapath #(
        .TAPS (TAPS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req_type       (i_req_type),
        .i_sample_left    (i_sample_left),
        .i_sample_right   (i_sample_right),
        .i_coef_channel   (i_coef_channel),
        .i_coef_index     (i_coef_index),
        .i_coef_value     (i_coef_value),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_out_left       (o_out_left),
        .o_out_right      (o_out_right),
        .o_in_peak_left   (o_in_peak_left),
        .o_in_peak_right  (o_in_peak_right),
        .o_out_peak_left  (o_out_peak_left),
        .o_out_peak_right (o_out_peak_right)
    );

endmodule
